// ===== rtl/quaternion_to_euler_angles_unit_macros.svh =====
// Assertion macros for the RTL file that checks itself.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_MACROS_SVH

// Checked only outside reset.
`define Q2E_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define Q2E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/q2e_pkg.sv =====
package q2e_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int SUM_W      = 34;
  localparam int CX_W       = 37;
  localparam int ANG_W      = 34;
  localparam int ROOT_W     = 29;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int ABS_W      = 28;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int PIPE_LAT   = 3 + SQRT_STAGES + CORDIC_LAT + 1;

  typedef logic signed [15:0]      quat_t;
  typedef logic signed [31:0]      prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [CX_W-1:0]  cx_t;
  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic [RAD_W-1:0]        rad_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic [REM_W-1:0]        rem_t;

  typedef struct packed {
    sum_t sr;
    sum_t cr;
    sum_t sy;
    sum_t cy;
    sum_t s;
  } side_t;

  localparam angle_t PI_Q30      = angle_t'(64'sd3373259426);
  localparam angle_t HALF_PI_Q30 = angle_t'(64'sd1686629713);
  localparam sum_t   ONE_Q28     = sum_t'(64'sd268435456);

  function automatic angle_t atan_entry(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return angle_t'({1'b0, v});
  endfunction

  function automatic angle_t round_angle(input angle_t zq);
    angle_t half;
    half = angle_t'(64'sd1 <<< (29 - ANGLE_FRAC_BITS));
    return (zq + half) >>> (30 - ANGLE_FRAC_BITS);
  endfunction

  function automatic angle_t clamp_sym(input angle_t v, input angle_t lim);
    angle_t r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  localparam angle_t LIM_PI   = round_angle(PI_Q30);
  localparam angle_t LIM_HALF = round_angle(HALF_PI_Q30);

endpackage

// ===== rtl/q2e_sqrt.sv =====
module q2e_sqrt (
  input  logic          clk,
  input  logic          en,
  input  q2e_pkg::rad_t rad,
  output q2e_pkg::root_t root
);
  import q2e_pkg::*;

  rad_t  rad_s  [0:SQRT_STAGES];
  rem_t  rem_s  [0:SQRT_STAGES];
  root_t root_s [0:SQRT_STAGES];

  assign rad_s[0]  = rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign cur   = {rem_s[k], rad_s[k][2*(ROOT_W-1-k) +: 2]};
    assign trial = (REM_W + 2)'({root_s[k], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1]  <= rad_s[k];
        rem_s[k+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_s[SQRT_STAGES];

endmodule

// ===== rtl/q2e_cordic.sv =====
module q2e_cordic (
  input  logic            clk,
  input  logic            en,
  input  q2e_pkg::sum_t   y_in,
  input  q2e_pkg::sum_t   x_in,
  output q2e_pkg::angle_t angle
);
  import q2e_pkg::*;

  cx_t    xs   [0:CORDIC_STEPS];
  cx_t    ys   [0:CORDIC_STEPS];
  angle_t zs   [0:CORDIC_STEPS];
  logic   zero [0:CORDIC_STEPS];

  // The left half plane is folded over by a rotation of plus or minus pi.
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -CX_W'(x_in);
        ys[0] <= -CX_W'(y_in);
        zs[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        xs[0] <= CX_W'(x_in);
        ys[0] <= CX_W'(y_in);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(i);
        end
      end
    end
  end

  assign angle = zero[CORDIC_STEPS] ? '0 : zs[CORDIC_STEPS];

endmodule

// ===== rtl/quaternion_to_euler_angles_unit.sv =====
// Quaternion to ZYX Euler angles.
// The input channel (in_valid, in_ready) carries one attitude quaternion per
// transaction in signed Q2.14. The output channel (out_valid, out_ready)
// returns roll, pitch and yaw in radians with 13 fraction bits, plus a flag
// that marks a pitch forced to plus or minus pi/2.
// The block is one pipeline of 50 register stages: three for the products,
// sums and square, 29 for the bit-per-stage square root, 17 for the
// vectoring CORDIC and one output register. One transaction is accepted
// every cycle while the output register is not stalled.
// The whole pipeline advances whenever the output register is empty or is
// being read; in_ready follows that enable. When the receiver stalls a full
// output register, the pipeline holds and nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
`include "quaternion_to_euler_angles_unit_macros.svh"

module quaternion_to_euler_angles_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  q2e_pkg::quat_t      quat_w,
  input  q2e_pkg::quat_t      quat_x,
  input  q2e_pkg::quat_t      quat_y,
  input  q2e_pkg::quat_t      quat_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  roll_angle,
  output logic signed [14:0]  pitch_angle,
  output logic signed [15:0]  yaw_angle,
  output logic                pitch_clamped
);
  import q2e_pkg::*;

  logic                en;
  logic [PIPE_LAT-1:0] vld;

  prod_t wx, yz, xx, yy, wz, xy, zz, wy, zx;
  side_t side2;
  logic  clamp2;
  logic  [ABS_W-1:0] abs2;
  sum_t  s_comb;
  sum_t  s_abs;
  rad_t  rad3;
  side_t side_d [0:SQRT_STAGES];
  logic  clamp_d [0:SQRT_STAGES+CORDIC_LAT];
  logic  pos_d   [0:SQRT_STAGES+CORDIC_LAT];
  root_t root;
  angle_t roll_z, pitch_z, yaw_z;
  angle_t roll_r, pitch_r, yaw_r;
  side_t  side_c;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= quat_w * quat_x;
      yz <= quat_y * quat_z;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      wz <= quat_w * quat_z;
      xy <= quat_x * quat_y;
      zz <= quat_z * quat_z;
      wy <= quat_w * quat_y;
      zx <= quat_z * quat_x;
    end
  end

  assign s_comb = (SUM_W'(wy) - SUM_W'(zx)) <<< 1;
  assign s_abs  = (s_comb < 0) ? -s_comb : s_comb;

  always_ff @(posedge clk) begin
    if (en) begin
      side2.sr <= (SUM_W'(wx) + SUM_W'(yz)) <<< 1;
      side2.cr <= ONE_Q28 - ((SUM_W'(xx) + SUM_W'(yy)) <<< 1);
      side2.sy <= (SUM_W'(wz) + SUM_W'(xy)) <<< 1;
      side2.cy <= ONE_Q28 - ((SUM_W'(yy) + SUM_W'(zz)) <<< 1);
      side2.s  <= s_comb;
      clamp2   <= (s_comb >= ONE_Q28) || (s_comb <= -ONE_Q28);
      abs2     <= s_abs[ABS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad3       <= (RAD_W'(1) << (2 * ABS_W)) - RAD_W'(abs2 * abs2);
      side_d[0]  <= side2;
      clamp_d[0] <= clamp2;
      pos_d[0]   <= side2.s > 0;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
        side_d[k] <= side_d[k-1];
      end
      for (int k = 1; k <= SQRT_STAGES + CORDIC_LAT; k++) begin
        clamp_d[k] <= clamp_d[k-1];
        pos_d[k]   <= pos_d[k-1];
      end
    end
  end

  q2e_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad3),
    .root (root)
  );

  assign side_c = side_d[SQRT_STAGES];

  q2e_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (side_c.sr),
    .x_in  (side_c.cr),
    .angle (roll_z)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (side_c.s),
    .x_in  (SUM_W'(root)),
    .angle (pitch_z)
  );

  q2e_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (side_c.sy),
    .x_in  (side_c.cy),
    .angle (yaw_z)
  );

  assign roll_r = clamp_sym(round_angle(roll_z), LIM_PI);
  assign yaw_r  = clamp_sym(round_angle(yaw_z), LIM_PI);

  always_comb begin
    if (clamp_d[SQRT_STAGES+CORDIC_LAT]) begin
      pitch_r = pos_d[SQRT_STAGES+CORDIC_LAT] ? LIM_HALF : -LIM_HALF;
    end else begin
      pitch_r = clamp_sym(round_angle(pitch_z), LIM_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle    <= roll_r[15:0];
      pitch_angle   <= pitch_r[14:0];
      yaw_angle     <= yaw_r[15:0];
      pitch_clamped <= clamp_d[SQRT_STAGES+CORDIC_LAT];
    end
  end

  `Q2E_ASSERT_NR(a_ready_follows_output, in_ready == (!out_valid || out_ready), "in_ready does not match the output stall")
  `Q2E_ASSERT(a_reset_empties, rst |=> !out_valid, "output valid after reset")
  `Q2E_ASSERT_NR(a_clamp_value, (out_valid && pitch_clamped) |-> ((pitch_angle == LIM_HALF[14:0]) || (pitch_angle == 15'(-LIM_HALF))), "clamped pitch is not plus or minus pi/2")

endmodule
